### rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: assertion failed");

// Implication whose consequent is checked on the following clock edge.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

`endif

### rtl/fac_pkg.sv
// Types and constants for the feed-forward audio compressor.
package fac_pkg;

    localparam int unsigned SAMPLE_W    = 32;
    localparam int unsigned THRESH_W    = 32;
    localparam int unsigned COEF_W      = 24;
    localparam int unsigned MAKEUP_W    = 28;
    localparam int unsigned CFG_DATA_W  = 32;
    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned ROOT_STEPS  = 32;

    localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ATTACK    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_RELEASE   = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_MAKEUP    = 2'd3;

    localparam logic [THRESH_W-1:0] THRESHOLD_RST = 32'd539423517;
    localparam logic [COEF_W-1:0]   ATTACK_RST    = 24'd16568806;
    localparam logic [COEF_W-1:0]   RELEASE_RST   = 24'd16756258;
    localparam logic [MAKEUP_W-1:0] MAKEUP_RST    = 28'd23698445;

    localparam logic [COEF_W:0] COEF_ONE = 25'd16777216;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ENV0,
        S_ENV1,
        S_ENV2,
        S_CMP,
        S_SQ_LOAD,
        S_SQRT,
        S_DV_LOAD,
        S_DIV,
        S_GAIN0,
        S_GAIN1,
        S_OMUL,
        S_OSAT
    } state_t;

    // Command to the bit-serial root / divide unit.
    typedef struct packed {
        logic load;
        logic step;
        logic div_mode;
    } rd_cmd_t;

endpackage

### rtl/feed_forward_audio_compressor.sv
// Top level of the feed-forward 2:1 audio compressor.
//
// Input channel: in_valid / in_ready carry one signed Q1.31 sample_in per beat.
// Output channel: out_valid / out_ready carry one saturated sample_out per beat,
// one result for every accepted sample, in order.
// Configuration: cfg_we writes cfg_data to register cfg_index (0 threshold,
// 1 attack, 2 release, 3 makeup); write only while the block is idle.
// A sample below threshold goes from the envelope update straight to output
// scaling; above threshold, 32 root steps and 32 divide steps go through
// one shared subtractor, and one 32x32 multiplier is reused for the envelope,
// threshold product, makeup and output scaling. in_ready is low while a sample
// is in work: a new sample is taken only once the last one's result is loaded.
// The finished result sits in an output register; the next sample is accepted
// while it waits. If the receiver stalls, the block holds its last step until
// the register frees up, then continues.
// Reset clears the envelope and loads the default threshold (-12 dBFS),
// 5 ms attack, 50 ms release and +3 dB makeup gain.
module feed_forward_audio_compressor (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [fac_pkg::SAMPLE_W-1:0] sample_in,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [fac_pkg::SAMPLE_W-1:0] sample_out,
    input  logic                                cfg_we,
    input  logic [fac_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [fac_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import fac_pkg::*;

    state_t state_reg, state_next;

    logic [THRESH_W-1:0] threshold_reg;
    logic [COEF_W-1:0]   attack_reg;
    logic [COEF_W-1:0]   release_reg;
    logic [MAKEUP_W-1:0] makeup_reg;

    logic [31:0]         envelope_reg, envelope_next;
    logic [31:0]         mag_reg, mag_in;
    logic                neg_reg;
    logic [COEF_W-1:0]   coef_reg, coef_in;
    logic [55:0]         acc_reg;
    logic [63:0]         prod_reg;
    logic [MAKEUP_W-1:0] gain_reg, gain_next;
    logic [4:0]          cnt_reg, cnt_next;
    logic                out_valid_reg;
    logic [31:0]         sample_out_reg;

    logic [31:0] mul_a, mul_b;
    logic [57:0] env_sum;
    logic [63:0] gain_sum, out_sum;
    logic [30:0] omag;
    logic [31:0] out_word;
    logic        in_beat, out_free, load_out, load_gain;
    logic        load_env, load_acc;
    rd_cmd_t     rd_cmd;
    logic [31:0] rd_result;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_beat   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign sample_out = sample_out_reg;

    assign mag_in  = sample_in[31] ? (32'd0 - sample_in) : sample_in;
    assign coef_in = (mag_in > envelope_reg) ? attack_reg : release_reg;

    assign env_sum       = {2'b00, acc_reg} + {1'b0, prod_reg[56:0]} + 58'd8388608;
    assign envelope_next = env_sum[55:24];
    assign gain_sum      = prod_reg + 64'd2147483648;
    assign gain_next     = gain_sum[59:32];
    assign out_sum       = prod_reg + 64'd8388608;
    assign omag          = (out_sum[63:55] != 9'd0) ? 31'h7FFFFFFF : out_sum[54:24];
    assign out_word      = neg_reg ? (32'd0 - {1'b0, omag}) : {1'b0, omag};

    fac_rootdiv u_rootdiv (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (rd_cmd),
        .radicand ({prod_reg[61:0], 2'b00}),
        .divisor  (envelope_reg),
        .result   (rd_result)
    );

    // Sequencer: picks multiplier operands and drives the root/divide unit.
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        mul_a      = '0;
        mul_b      = '0;
        rd_cmd     = '0;
        load_env   = 1'b0;
        load_acc   = 1'b0;
        load_gain  = 1'b0;
        load_out   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_beat)
                    state_next = S_ENV0;
            end
            S_ENV0:
            begin
                mul_a      = {8'd0, coef_reg};
                mul_b      = envelope_reg;
                state_next = S_ENV1;
            end
            S_ENV1:
            begin
                mul_a      = {7'd0, COEF_ONE - {1'b0, coef_reg}};
                mul_b      = mag_reg;
                load_acc   = 1'b1;
                state_next = S_ENV2;
            end
            S_ENV2:
            begin
                load_env   = 1'b1;
                state_next = S_CMP;
            end
            S_CMP:
            begin
                mul_a = threshold_reg;
                mul_b = envelope_reg;
                if (envelope_reg > threshold_reg)
                    state_next = S_SQ_LOAD;
                else
                    state_next = S_OMUL;
            end
            S_SQ_LOAD:
            begin
                rd_cmd.load = 1'b1;
                cnt_next    = 5'(ROOT_STEPS - 1);
                state_next  = S_SQRT;
            end
            S_SQRT:
            begin
                rd_cmd.step = 1'b1;
                cnt_next    = cnt_reg - 5'd1;
                if (cnt_reg == 5'd0)
                    state_next = S_DV_LOAD;
            end
            S_DV_LOAD:
            begin
                rd_cmd.load     = 1'b1;
                rd_cmd.div_mode = 1'b1;
                cnt_next        = 5'(ROOT_STEPS - 1);
                state_next      = S_DIV;
            end
            S_DIV:
            begin
                rd_cmd.step     = 1'b1;
                rd_cmd.div_mode = 1'b1;
                cnt_next        = cnt_reg - 5'd1;
                if (cnt_reg == 5'd0)
                    state_next = S_GAIN0;
            end
            S_GAIN0:
            begin
                mul_a      = rd_result;
                mul_b      = {4'd0, makeup_reg};
                state_next = S_GAIN1;
            end
            S_GAIN1:
            begin
                load_gain  = 1'b1;
                state_next = S_OMUL;
            end
            S_OMUL:
            begin
                mul_a      = mag_reg;
                mul_b      = {4'd0, gain_reg};
                state_next = S_OSAT;
            end
            S_OSAT:
            begin
                // keep the output product in place while the result register is busy
                mul_a = mag_reg;
                mul_b = {4'd0, gain_reg};
                if (out_free)
                begin
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            envelope_reg  <= '0;
            out_valid_reg <= 1'b0;
            threshold_reg <= THRESHOLD_RST;
            attack_reg    <= ATTACK_RST;
            release_reg   <= RELEASE_RST;
            makeup_reg    <= MAKEUP_RST;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (load_env)
                envelope_reg <= envelope_next;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_THRESHOLD: threshold_reg <= cfg_data;
                    REG_ATTACK:    attack_reg    <= cfg_data[COEF_W-1:0];
                    REG_RELEASE:   release_reg   <= cfg_data[COEF_W-1:0];
                    REG_MAKEUP:    makeup_reg    <= cfg_data[MAKEUP_W-1:0];
                    default:       ;
                endcase
            end
        end
    end

    // Datapath registers, no reset needed.
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        if (in_beat)
        begin
            mag_reg  <= mag_in;
            neg_reg  <= sample_in[31];
            coef_reg <= coef_in;
        end
        if (load_acc)
            acc_reg <= prod_reg[55:0];
        if (state_reg == S_CMP)
            gain_reg <= makeup_reg;
        else if (load_gain)
            gain_reg <= gain_next;
        if (load_out)
            sample_out_reg <= out_word;
    end

endmodule

### rtl/fac_rootdiv.sv
// Bit-serial square root and restoring divide sharing one subtractor.
module fac_rootdiv (
    input  logic             clk,
    input  logic             rst_n,
    input  fac_pkg::rd_cmd_t cmd,
    input  logic [63:0]      radicand,
    input  logic [31:0]      divisor,
    output logic [31:0]      result
);
    import fac_pkg::*;

    logic [32:0] rem_reg, rem_next;
    logic [63:0] bits_reg, bits_next;
    logic [31:0] res_reg, res_next;
    logic [34:0] sub_a, sub_b;
    logic [35:0] diff;
    logic        ge;

    always_comb
    begin
        if (cmd.div_mode)
        begin
            sub_a = {2'b00, rem_reg[31:0], bits_reg[63]};
            sub_b = {3'b000, divisor};
        end
        else
        begin
            sub_a = {rem_reg, bits_reg[63:62]};
            sub_b = {1'b0, res_reg, 2'b01};
        end
        diff = {1'b0, sub_a} - {1'b0, sub_b};
        ge   = !diff[35];

        rem_next  = rem_reg;
        bits_next = bits_reg;
        res_next  = res_reg;
        if (cmd.load)
        begin
            if (cmd.div_mode)
            begin
                // numerator is root << 31: top part root >> 1, then root[0], then zeros
                rem_next  = {2'b00, res_reg[31:1]};
                bits_next = {res_reg[0], 63'd0};
            end
            else
            begin
                rem_next  = '0;
                bits_next = radicand;
            end
            res_next = '0;
        end
        else if (cmd.step)
        begin
            rem_next  = ge ? diff[32:0] : sub_a[32:0];
            res_next  = {res_reg[30:0], ge};
            bits_next = cmd.div_mode ? {bits_reg[62:0], 1'b0} : {bits_reg[61:0], 2'b00};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= '0;
            bits_reg <= '0;
            res_reg  <= '0;
        end
        else
        begin
            rem_reg  <= rem_next;
            bits_reg <= bits_next;
            res_reg  <= res_next;
        end
    end

    assign result = res_reg;

endmodule

### rtl/fac_checker.sv
// Port-level checker for the audio compressor, bound to the top level.
`include "assert_macros.svh"

module fac_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_valid,
    input logic                                in_ready,
    input logic                                out_valid,
    input logic                                out_ready,
    input logic signed [fac_pkg::SAMPLE_W-1:0] sample_out
);
    import fac_pkg::*;

    // stalled result beat holds
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(sample_out))

    // saturation is symmetric: the most negative code never leaves
    `ASSERT_IMPLY(a_out_sym, clk, rst_n, out_valid, sample_out != 32'sh80000000)

    // one sample at a time: busy right after an input beat
    `ASSERT_NEXT(a_busy, clk, rst_n, rst_n && in_valid && in_ready, !in_ready)

    // a result never appears in the cycle right after its input beat
    `ASSERT_NEXT(a_no_early, clk, rst_n, rst_n && in_valid && in_ready, !$rose(out_valid))

endmodule

bind feed_forward_audio_compressor fac_checker u_fac_checker (.*);
